/* design/pspc_pkg.sv */
// Package with the payload types, the arctangent table and gain constants of the converter.
package pspc_pkg;

  localparam int          DATA_WIDTH   = 32;
  localparam int unsigned ATAN_ENTRIES = 40;
  localparam int unsigned GUARD        = 8;
  localparam logic [29:0] GAIN_INF     = 30'd652032874;
  localparam logic [29:0] GAIN_TAIL    = 30'd434688583;

  typedef enum logic {
    OP_POL2CART = 1'b0,
    OP_CART2POL = 1'b1
  } op_t;

  typedef struct packed {
    logic                  opcode;
    logic [DATA_WIDTH-1:0] coord_first;
    logic [DATA_WIDTH-1:0] coord_second;
    logic [DATA_WIDTH-1:0] coord_third;
    logic [DATA_WIDTH-1:0] coord_fourth;
  } in_item_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] result_first;
    logic [DATA_WIDTH-1:0] result_second;
    logic [DATA_WIDTH-1:0] result_third;
    logic [DATA_WIDTH-1:0] result_fourth;
    logic                  saturated;
  } out_item_t;

  // Arctangent of 2^-i as a binary angle with pi = 2^31.
  function automatic logic [31:0] atan_entry(input int unsigned idx);
    logic [31:0] r;
    begin
      case (idx)
        0: r = 32'h20000000;  1: r = 32'h12E4051D;  2: r = 32'h09FB385B;
        3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
        6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
        9: r = 32'h00145F2E;  10: r = 32'h000A2F98; 11: r = 32'h000517CC;
        12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2F9;
        15: r = 32'h0000517C; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
        18: r = 32'h00000A2F; 19: r = 32'h00000517; 20: r = 32'h0000028B;
        21: r = 32'h00000145; 22: r = 32'h000000A2; 23: r = 32'h00000051;
        24: r = 32'h00000028; 25: r = 32'h00000014; 26: r = 32'h0000000A;
        27: r = 32'h00000005; 28: r = 32'h00000002; 29: r = 32'h00000001;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction

endpackage

/* design/phase_space_polar_cartesian_top.sv */
// Top level of the pipelined CORDIC polar/Cartesian phase-space converter.
//
// Usage: one input channel (in_valid/in_stall/in_data) carries transactions of
// an opcode and four coordinates; one output channel (out_valid/out_stall/
// out_data) returns exactly one result transaction for each input, in order.
// Opcode 0 rotates (R,0) and (vR,vT) by the binary angle phi to give x, y, vx,
// vy. Opcode 1 vectors (x,y) onto the x axis to give R and phi = atan2(y,x),
// turning (vx,vy) by -phi into (vR,vT). The origin gives R = 0, phi = 0 and
// passes the velocity through.
// The pipeline has one entry stage, one register per CORDIC micro-rotation,
// one magnitude stage, one gain multiply stage and one rounding and saturation
// stage.
// Throughput is one transaction per cycle, since every stage takes a new
// transaction in each cycle that the pipeline advances.
// When the receiver stalls, the whole pipeline holds only if the output stage
// is full, and in_stall rises with it, so nothing is lost or repeated. Synchronous
// reset clears every valid bit; payload registers are not reset.
module phase_space_polar_cartesian_top #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  pspc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pspc_pkg::out_item_t out_data
);
  import pspc_pkg::*;

  localparam int N  = (CORDIC_STAGES > int'(ATAN_ENTRIES)) ? int'(ATAN_ENTRIES) : CORDIC_STAGES;
  localparam int IW = DATA_WIDTH + int'(GUARD) + 3;   // internal width with growth margin
  localparam int SH = (2 * N < 30) ? 2 * N : 30;
  localparam logic [29:0] GAIN_K = GAIN_INF + (GAIN_TAIL >> SH);
  localparam int PW = IW + 31;                        // product width

  typedef struct packed {
    logic          cart;    // opcode 1
    logic          zero;    // origin case
    logic signed [IW-1:0] px, py, qx, qy;
    logic signed [32:0]   z;
    logic [DATA_WIDTH-1:0] pass_x, pass_y;
  } rot_t;

  // Single global enable: the pipeline advances unless output is full and stalled.
  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  // ---------------- entry stage ----------------
  logic signed [DATA_WIDTH-1:0] a_in, b_in, c_in, d_in;
  assign a_in = in_data.coord_first[DATA_WIDTH-1:0];
  assign b_in = in_data.coord_second[DATA_WIDTH-1:0];
  assign c_in = in_data.coord_third[DATA_WIDTH-1:0];
  assign d_in = in_data.coord_fourth[DATA_WIDTH-1:0];

  rot_t ent;
  always_comb begin
    logic signed [IW-1:0] a, b, c, d;
    logic [31:0] ang;
    a = IW'(a_in) <<< GUARD;
    b = IW'(b_in) <<< GUARD;
    c = IW'(c_in) <<< GUARD;
    d = IW'(d_in) <<< GUARD;
    ang = in_data.coord_fourth;
    ent = '0;
    ent.pass_x = c_in;
    ent.pass_y = d_in;
    if (op_t'(in_data.opcode) == OP_POL2CART) begin
      ent.cart = 1'b0;
      ent.px = a; ent.py = '0; ent.qx = b; ent.qy = c;
      if (ang >= 32'h40000000 && ang < 32'hC0000000) begin
        ent.px = -a; ent.qx = -b; ent.qy = -c;
        ang = ang + 32'h80000000;
      end
      ent.z = 33'(signed'(ang));
    end else begin
      ent.cart = 1'b1;
      ent.zero = (a_in == '0) && (b_in == '0);
      ent.px = a; ent.py = b; ent.qx = c; ent.qy = d;
      ent.z = '0;
      if (a_in < 0) begin
        ent.px = -a; ent.py = -b; ent.qx = -c; ent.qy = -d;
        ent.z = 33'sh080000000;
      end
    end
  end

  rot_t st [N+1];
  logic vl [N+1];

  always_ff @(posedge clk) begin
    if (rst) vl[0] <= 1'b0;
    else if (adv) vl[0] <= in_valid;
    if (adv) st[0] <= ent;
  end

  // ---------------- micro-rotation stages ----------------
  for (genvar i = 0; i < N; i++) begin : g_rot
    rot_t nx;
    always_comb begin
      logic dir;   // 1: rotate counterclockwise
      nx = st[i];
      dir = st[i].cart ? st[i].py[IW-1] : !st[i].z[32];
      if (dir) begin
        nx.px = st[i].px - (st[i].py >>> i);
        nx.py = st[i].py + (st[i].px >>> i);
        nx.qx = st[i].qx - (st[i].qy >>> i);
        nx.qy = st[i].qy + (st[i].qx >>> i);
      end else begin
        nx.px = st[i].px + (st[i].py >>> i);
        nx.py = st[i].py - (st[i].px >>> i);
        nx.qx = st[i].qx + (st[i].qy >>> i);
        nx.qy = st[i].qy - (st[i].qx >>> i);
      end
      // A counterclockwise step uses up angle in both modes.
      if (dir) nx.z = st[i].z - 33'(atan_entry(i));
      else     nx.z = st[i].z + 33'(atan_entry(i));
    end
    always_ff @(posedge clk) begin
      if (rst) vl[i+1] <= 1'b0;
      else if (adv) vl[i+1] <= vl[i];
      if (adv) st[i+1] <= nx;
    end
  end

  // ---------------- gain stage A: magnitudes ----------------
  typedef struct packed {
    logic [3:0] neg;
    logic [3:0][IW-1:0] mag;
    logic cart, zero;
    logic [31:0] z;
    logic [DATA_WIDTH-1:0] pass_x, pass_y;
  } mag_t;

  mag_t ma, ma_r;
  logic va;
  always_comb begin
    logic signed [IW-1:0] v [4];
    v[0] = st[N].px;
    v[1] = st[N].cart ? st[N].qx : st[N].py;
    v[2] = st[N].cart ? st[N].qy : st[N].qx;
    v[3] = st[N].qy;
    for (int k = 0; k < 4; k++) begin
      ma.neg[k] = v[k][IW-1];
      ma.mag[k] = v[k][IW-1] ? IW'(-v[k]) : IW'(v[k]);
    end
    ma.cart = st[N].cart; ma.zero = st[N].zero;
    ma.z = st[N].z[31:0];
    ma.pass_x = st[N].pass_x; ma.pass_y = st[N].pass_y;
  end
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (adv) va <= vl[N];
    if (adv) ma_r <= ma;
  end

  // ---------------- gain stage B: multiply by K ----------------
  typedef struct packed {
    logic [3:0] neg;
    logic [3:0][PW-1:0] prod;
    logic cart, zero;
    logic [31:0] z;
    logic [DATA_WIDTH-1:0] pass_x, pass_y;
  } prod_t;

  prod_t pb, pb_r;
  logic vb;
  always_comb begin
    logic [PW-1:0] hi, lo;
    for (int k = 0; k < 4; k++) begin
      hi = PW'(ma_r.mag[k] >> 30) * PW'(GAIN_K);
      lo = (PW'(ma_r.mag[k][29:0]) * PW'(GAIN_K) + (PW'(1) << 29)) >> 30;
      pb.prod[k] = hi + lo;
    end
    pb.neg = ma_r.neg; pb.cart = ma_r.cart; pb.zero = ma_r.zero; pb.z = ma_r.z;
    pb.pass_x = ma_r.pass_x; pb.pass_y = ma_r.pass_y;
  end
  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (adv) vb <= va;
    if (adv) pb_r <= pb;
  end

  // ---------------- rounding and saturation ----------------
  out_item_t fin;
  always_comb begin
    logic [PW-1:0] p, lim;
    logic [DATA_WIDTH-1:0] r [4];
    logic sat;
    sat = 1'b0;
    lim = PW'(1) << (DATA_WIDTH - 1);
    for (int k = 0; k < 4; k++) begin
      p = (pb_r.prod[k] + (PW'(1) << (GUARD - 1))) >> GUARD;
      if (!pb_r.neg[k] && p > lim - 1) begin p = lim - 1; sat = 1'b1; end
      if (pb_r.neg[k] && p > lim) begin p = lim; sat = 1'b1; end
      r[k] = pb_r.neg[k] ? DATA_WIDTH'(-p) : DATA_WIDTH'(p);
    end
    fin = '0;
    fin.result_first  = 32'(signed'(r[0]));
    fin.result_second = 32'(signed'(r[1]));
    fin.result_third  = 32'(signed'(r[2]));
    fin.result_fourth = pb_r.cart ? pb_r.z : 32'(signed'(r[3]));
    fin.saturated     = sat;
    if (pb_r.cart && pb_r.zero) begin
      fin.result_first  = '0;
      fin.result_second = 32'(signed'(pb_r.pass_x));
      fin.result_third  = 32'(signed'(pb_r.pass_y));
      fin.result_fourth = '0;
      fin.saturated     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= vb;
    if (adv) out_data <= fin;
  end

endmodule

/* design/pspc_checker.sv */
// Port-level checker for the converter, bound to the top level.
module pspc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input pspc_pkg::out_item_t out_data
);
  import pspc_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("out_valid dropped while stalled");
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data)) else $error("output changed while stalled");
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall) else $error("input stalled with room in the pipeline");
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("output valid right after reset");

endmodule

bind phase_space_polar_cartesian_top pspc_checker u_pspc_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
